// File: src/gdod_pkg.sv
`default_nettype none

package gdod_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int OFF_W   = 23;
   localparam int DIFF_W  = 23;

   // calendar limits
   localparam int MAX_YEAR = 9999;
   localparam int MONTHS   = 12;
   localparam int YEAR0_DAYS = 366;

   // internal day numbers, signed, day 0 is 0001-01-01
   localparam int DN_W   = 26;
   localparam int SPAN_W = 18;
   localparam int CNT_W  = 8;
   localparam int DBM_W  = 9;

   // last legal day number, MAX_YEAR-12-31
   localparam int TOP_DAYS = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                             + MAX_YEAR / 400 - 1;
   localparam logic signed [DN_W-1:0] TOP_DN  = DN_W'(TOP_DAYS);
   localparam logic signed [DN_W-1:0] DIFF_HI = DN_W'(2 ** (DIFF_W - 1) - 1);
   localparam logic signed [DN_W-1:0] DIFF_LO = DN_W'(-(2 ** (DIFF_W - 1)));

   // digit limits of the year decomposition
   localparam int CENT_LAST = 3;
   localparam int QUAD_LAST = 24;
   localparam int YEAR_LAST = 3;

   typedef enum logic [1:0] {
      PH_ERA,
      PH_CENT,
      PH_QUAD,
      PH_YEAR
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_FWD_LOAD,
      CMD_WALK,
      CMD_FWD_MONTH,
      CMD_DIFF,
      CMD_INV_LOAD,
      CMD_INV_MONTH,
      CMD_FINISH
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       capture;
      logic       sel_other;
      logic       inverse;
      phase_type  phase;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_step;
      logic month_step;
   } dp_status_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  base_year;
      logic [MONTH_W-1:0] base_month;
      logic [DAY_W-1:0]   base_day;
      logic [OFF_W-1:0]   offset_days;
      logic [YEAR_W-1:0]  other_year;
      logic [MONTH_W-1:0] other_month;
      logic [DAY_W-1:0]   other_day;
   } req_item_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  result_year;
      logic [MONTH_W-1:0] result_month;
      logic [DAY_W-1:0]   result_day;
      logic [DIFF_W-1:0]  day_difference;
      logic               base_after_other;
      logic               dates_equal;
      logic               base_valid;
      logic               result_out_of_range;
   } rsp_item_type;

   // month 0 counts as january, 13..15 as december
   function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] r;
      if (m == '0) begin
         r = MONTH_W'(1);
      end else if (m > MONTH_W'(MONTHS)) begin
         r = MONTH_W'(MONTHS);
      end else begin
         r = m;
      end
      return r;
   endfunction

   // length of a month, leap day in february only
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] r;
      case (m)
         MONTH_W'(2):  r = leap ? DAY_W'(29) : DAY_W'(28);
         MONTH_W'(4):  r = DAY_W'(30);
         MONTH_W'(6):  r = DAY_W'(30);
         MONTH_W'(9):  r = DAY_W'(30);
         MONTH_W'(11): r = DAY_W'(30);
         default:      r = DAY_W'(31);
      endcase
      return r;
   endfunction

   // days in the year before the first of a month (month already clamped)
   function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m,
                                                          input logic leap);
      logic [DBM_W-1:0] r;
      case (m)
         MONTH_W'(1):  r = DBM_W'(0);
         MONTH_W'(2):  r = DBM_W'(31);
         MONTH_W'(3):  r = DBM_W'(59);
         MONTH_W'(4):  r = DBM_W'(90);
         MONTH_W'(5):  r = DBM_W'(120);
         MONTH_W'(6):  r = DBM_W'(151);
         MONTH_W'(7):  r = DBM_W'(181);
         MONTH_W'(8):  r = DBM_W'(212);
         MONTH_W'(9):  r = DBM_W'(243);
         MONTH_W'(10): r = DBM_W'(273);
         MONTH_W'(11): r = DBM_W'(304);
         default:      r = DBM_W'(334);
      endcase
      if (leap && m > MONTH_W'(2)) begin
         r = r + DBM_W'(1);
      end
      return r;
   endfunction

   // years per block of the decomposition
   function automatic logic [SPAN_W-1:0] block_years(input phase_type ph);
      logic [SPAN_W-1:0] r;
      case (ph)
         PH_ERA:  r = SPAN_W'(400);
         PH_CENT: r = SPAN_W'(100);
         PH_QUAD: r = SPAN_W'(4);
         default: r = SPAN_W'(1);
      endcase
      return r;
   endfunction

   // days per block of the decomposition
   function automatic logic [SPAN_W-1:0] block_days(input phase_type ph);
      logic [SPAN_W-1:0] r;
      case (ph)
         PH_ERA:  r = SPAN_W'(146097);
         PH_CENT: r = SPAN_W'(36524);
         PH_QUAD: r = SPAN_W'(1461);
         default: r = SPAN_W'(365);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/gdod_req_if.sv
`default_nettype none

interface gdod_req_if import gdod_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  base_year;
   logic [MONTH_W-1:0] base_month;
   logic [DAY_W-1:0]   base_day;
   logic [OFF_W-1:0]   offset_days;
   logic [YEAR_W-1:0]  other_year;
   logic [MONTH_W-1:0] other_month;
   logic [DAY_W-1:0]   other_day;

   modport source (
      output valid, base_year, base_month, base_day, offset_days,
             other_year, other_month, other_day,
      input  ready
   );

   modport sink (
      input  valid, base_year, base_month, base_day, offset_days,
             other_year, other_month, other_day,
      output ready
   );
endinterface

`default_nettype wire

// File: src/gdod_rsp_if.sv
`default_nettype none

interface gdod_rsp_if import gdod_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  result_year;
   logic [MONTH_W-1:0] result_month;
   logic [DAY_W-1:0]   result_day;
   logic [DIFF_W-1:0]  day_difference;
   logic               base_after_other;
   logic               dates_equal;
   logic               base_valid;
   logic               result_out_of_range;

   modport source (
      output valid, result_year, result_month, result_day, day_difference,
             base_after_other, dates_equal, base_valid, result_out_of_range,
      input  ready
   );

   modport sink (
      input  valid, result_year, result_month, result_day, day_difference,
             base_after_other, dates_equal, base_valid, result_out_of_range,
      output ready
   );
endinterface

`default_nettype wire

// File: src/gdod_ctrl.sv
`default_nettype none

module gdod_ctrl import gdod_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FWD_LOAD,
      S_FWD_WALK,
      S_FWD_MONTH,
      S_DIFF,
      S_INV_LOAD,
      S_INV_WALK,
      S_INV_MONTH,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      other_ff, other_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // sequencing of the two forward conversions, difference and back conversion
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      other_in      = other_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd.op        = CMD_NONE;
      cmd.capture   = 1'b0;
      cmd.sel_other = other_ff;
      cmd.inverse   = 1'b0;
      cmd.phase     = phase_ff;

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               other_in    = 1'b0;
               state_in    = S_FWD_LOAD;
            end
         end
         S_FWD_LOAD: begin
            cmd.op   = CMD_FWD_LOAD;
            phase_in = PH_ERA;
            state_in = S_FWD_WALK;
         end
         S_FWD_WALK: begin
            cmd.op = CMD_WALK;
            if (!status.walk_step) begin
               if (phase_ff == PH_YEAR) begin
                  state_in = S_FWD_MONTH;
               end else begin
                  phase_in = phase_type'(phase_ff + 2'd1);
               end
            end
         end
         S_FWD_MONTH: begin
            cmd.op = CMD_FWD_MONTH;
            if (other_ff) begin
               state_in = S_DIFF;
            end else begin
               other_in = 1'b1;
               state_in = S_FWD_LOAD;
            end
         end
         S_DIFF: begin
            cmd.op   = CMD_DIFF;
            state_in = S_INV_LOAD;
         end
         S_INV_LOAD: begin
            cmd.op   = CMD_INV_LOAD;
            phase_in = PH_ERA;
            state_in = S_INV_WALK;
         end
         S_INV_WALK: begin
            cmd.op      = CMD_WALK;
            cmd.inverse = 1'b1;
            if (!status.walk_step) begin
               if (phase_ff == PH_YEAR) begin
                  state_in = S_INV_MONTH;
               end else begin
                  phase_in = phase_type'(phase_ff + 2'd1);
               end
            end
         end
         S_INV_MONTH: begin
            cmd.op = CMD_INV_MONTH;
            if (!status.month_step) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ERA;
         other_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         other_ff     <= other_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/gdod_dpath.sv
`default_nettype none

module gdod_dpath import gdod_pkg::*; (
   input  logic          clock,
   input  dp_cmd_type    cmd,
   input  req_item_type  req_item,
   output dp_status_type status,
   output rsp_item_type  rsp_item
);

   req_item_type             item_ff, item_in;
   logic signed [DN_W-1:0]   acc_ff, acc_in;
   logic [DN_W-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     cent3_ff, cent3_in;
   logic                     quad24_ff, quad24_in;
   logic                     year3_ff, year3_in;
   logic                     yzero_ff, yzero_in;
   logic [MONTH_W-1:0]       month_ff, month_in;
   logic signed [DN_W-1:0]   base_dn_ff, base_dn_in;
   logic signed [DN_W-1:0]   other_dn_ff, other_dn_in;
   logic [DIFF_W-1:0]        diff_ff, diff_in;
   logic                     oor_ff, oor_in;
   logic                     valid_ff, valid_in;
   rsp_item_type             rsp_ff, rsp_in;

   logic [YEAR_W-1:0]        sel_year;
   logic [MONTH_W-1:0]       sel_month;
   logic [DAY_W-1:0]         sel_day;
   logic                     leap;
   logic [SPAN_W-1:0]        span;
   logic [SPAN_W-1:0]        gain;
   logic [DN_W-1:0]          span_ext;
   logic [DN_W-1:0]          gain_ext;
   logic                     capped;
   logic [DAY_W-1:0]         dim;
   logic signed [DN_W-1:0]   month_sum;
   logic signed [DN_W-1:0]   diff_full;
   logic signed [DN_W-1:0]   shifted;
   logic                     after;
   logic                     equal;

   // date picked by the command
   assign sel_year  = cmd.sel_other ? item_ff.other_year  : item_ff.base_year;
   assign sel_month = cmd.sel_other ? item_ff.other_month : item_ff.base_month;
   assign sel_day   = cmd.sel_other ? item_ff.other_day   : item_ff.base_day;

   // leap year from the digits of year - 1 left by the last walk
   assign leap = yzero_ff | (year3_ff & (~quad24_ff | cent3_ff));

   // shared walk unit: years to days forward, days to years backward
   assign span     = cmd.inverse ? block_days(cmd.phase)  : block_years(cmd.phase);
   assign gain     = cmd.inverse ? block_years(cmd.phase) : block_days(cmd.phase);
   assign span_ext = DN_W'(span);
   assign gain_ext = DN_W'(gain);
   assign capped   = ((cmd.phase == PH_CENT) && (cnt_ff == CNT_W'(CENT_LAST)))
                   | ((cmd.phase == PH_YEAR) && (cnt_ff == CNT_W'(YEAR_LAST)));

   assign status.walk_step  = (rem_ff >= span_ext) && !capped;

   // month walk of the shifted date
   assign dim = month_days(month_ff, leap);
   assign status.month_step = (month_ff < MONTH_W'(MONTHS)) && (rem_ff >= DN_W'(dim));

   // day number of the picked date once its year part is known
   assign month_sum = acc_ff
                    + $signed(DN_W'(days_before_month(clamp_month(sel_month), leap)))
                    + $signed(DN_W'(sel_day)) - $signed(DN_W'(1));

   assign diff_full = base_dn_ff - other_dn_ff;
   assign shifted   = base_dn_ff
                    + $signed({{(DN_W-OFF_W){item_ff.offset_days[OFF_W-1]}},
                               item_ff.offset_days});

   // raw field comparison
   assign equal = (item_ff.base_year == item_ff.other_year)
               && (item_ff.base_month == item_ff.other_month)
               && (item_ff.base_day == item_ff.other_day);
   assign after = (item_ff.base_year > item_ff.other_year)
               || ((item_ff.base_year == item_ff.other_year)
                   && (item_ff.base_month > item_ff.other_month))
               || ((item_ff.base_year == item_ff.other_year)
                   && (item_ff.base_month == item_ff.other_month)
                   && (item_ff.base_day > item_ff.other_day));

   // next values per command
   always_comb begin
      item_in     = item_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      cent3_in    = cent3_ff;
      quad24_in   = quad24_ff;
      year3_in    = year3_ff;
      yzero_in    = yzero_ff;
      month_in    = month_ff;
      base_dn_in  = base_dn_ff;
      other_dn_in = other_dn_ff;
      diff_in     = diff_ff;
      oor_in      = oor_ff;
      valid_in    = valid_ff;
      rsp_in      = rsp_ff;

      if (cmd.capture) begin
         item_in = req_item;
      end

      case (cmd.op)
         CMD_FWD_LOAD: begin
            cnt_in    = '0;
            cent3_in  = 1'b0;
            quad24_in = 1'b0;
            year3_in  = 1'b0;
            if (sel_year == '0) begin
               // year zero: leap year just before year one
               acc_in   = $signed('0 - DN_W'(YEAR0_DAYS));
               rem_in   = '0;
               yzero_in = 1'b1;
            end else begin
               acc_in   = '0;
               rem_in   = DN_W'(sel_year) - DN_W'(1);
               yzero_in = 1'b0;
            end
         end
         CMD_WALK: begin
            if (status.walk_step) begin
               rem_in = rem_ff - span_ext;
               acc_in = acc_ff + $signed(gain_ext);
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               // phase over, keep the digit facts for the leap test
               cnt_in = '0;
               case (cmd.phase)
                  PH_CENT: cent3_in  = (cnt_ff == CNT_W'(CENT_LAST));
                  PH_QUAD: quad24_in = (cnt_ff == CNT_W'(QUAD_LAST));
                  PH_YEAR: year3_in  = (cnt_ff == CNT_W'(YEAR_LAST));
                  default: begin
                  end
               endcase
            end
         end
         CMD_FWD_MONTH: begin
            if (cmd.sel_other) begin
               other_dn_in = month_sum;
            end else begin
               base_dn_in = month_sum;
               valid_in   = (item_ff.base_month != '0)
                         && (item_ff.base_month <= MONTH_W'(MONTHS))
                         && (item_ff.base_day != '0)
                         && (item_ff.base_day <= month_days(item_ff.base_month, leap));
            end
         end
         CMD_DIFF: begin
            if (diff_full > DIFF_HI) begin
               diff_in = DIFF_HI[DIFF_W-1:0];
            end else if (diff_full < DIFF_LO) begin
               diff_in = DIFF_LO[DIFF_W-1:0];
            end else begin
               diff_in = diff_full[DIFF_W-1:0];
            end
         end
         CMD_INV_LOAD: begin
            // saturate the shifted day number to the legal years
            if (shifted[DN_W-1]) begin
               rem_in = '0;
               oor_in = 1'b1;
            end else if (shifted > TOP_DN) begin
               rem_in = TOP_DN;
               oor_in = 1'b1;
            end else begin
               rem_in = shifted;
               oor_in = 1'b0;
            end
            acc_in    = $signed(DN_W'(1));
            cnt_in    = '0;
            cent3_in  = 1'b0;
            quad24_in = 1'b0;
            year3_in  = 1'b0;
            yzero_in  = 1'b0;
            month_in  = MONTH_W'(1);
         end
         CMD_INV_MONTH: begin
            if (status.month_step) begin
               rem_in   = rem_ff - DN_W'(dim);
               month_in = month_ff + MONTH_W'(1);
            end
         end
         CMD_FINISH: begin
            rsp_in.result_year         = acc_ff[YEAR_W-1:0];
            rsp_in.result_month        = month_ff;
            rsp_in.result_day          = rem_ff[DAY_W-1:0] + DAY_W'(1);
            rsp_in.day_difference      = diff_ff;
            rsp_in.base_after_other    = after;
            rsp_in.dates_equal         = equal;
            rsp_in.base_valid          = valid_ff;
            rsp_in.result_out_of_range = oor_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      cent3_ff    <= cent3_in;
      quad24_ff   <= quad24_in;
      year3_ff    <= year3_in;
      yzero_ff    <= yzero_in;
      month_ff    <= month_in;
      base_dn_ff  <= base_dn_in;
      other_dn_ff <= other_dn_in;
      diff_ff     <= diff_in;
      oor_ff      <= oor_in;
      valid_ff    <= valid_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

// File: src/gregorian_date_offset_and_difference_core.sv
// time from request taken to result valid is set by the year walk
// through the single subtract and accumulate unit (two dates in, one date out)
// throughput: one request at a time; the next is taken once the result sits
// in the output register, while that result still waits to be taken
// reset: synchronous, active high; clears the controller and the result valid,
// no other state survives between requests
`default_nettype none

module gregorian_date_offset_and_difference_core import gdod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gdod_req_if.sink    req_chan,
   gdod_rsp_if.source  rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;
   req_item_type  req_item;
   rsp_item_type  rsp_item;

   // request payload into one word
   assign req_item.base_year   = req_chan.base_year;
   assign req_item.base_month  = req_chan.base_month;
   assign req_item.base_day    = req_chan.base_day;
   assign req_item.offset_days = req_chan.offset_days;
   assign req_item.other_year  = req_chan.other_year;
   assign req_item.other_month = req_chan.other_month;
   assign req_item.other_day   = req_chan.other_day;

   gdod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gdod_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // result register out to the channel
   assign rsp_chan.result_year         = rsp_item.result_year;
   assign rsp_chan.result_month        = rsp_item.result_month;
   assign rsp_chan.result_day          = rsp_item.result_day;
   assign rsp_chan.day_difference      = rsp_item.day_difference;
   assign rsp_chan.base_after_other    = rsp_item.base_after_other;
   assign rsp_chan.dates_equal         = rsp_item.dates_equal;
   assign rsp_chan.base_valid          = rsp_item.base_valid;
   assign rsp_chan.result_out_of_range = rsp_item.result_out_of_range;

endmodule

`default_nettype wire

// File: src/gdod_checker.sv
`default_nettype none

module gdod_checker import gdod_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [YEAR_W-1:0] rsp_result_year,
   input logic [DIFF_W-1:0] rsp_day_difference
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_year)
                                   && $stable(rsp_day_difference))
      else $error("result changed while stalled");

   // nothing valid straight out of reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no result rises right after a request is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after request");

endmodule

bind gregorian_date_offset_and_difference_core gdod_checker u_gdod_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_result_year    (rsp_chan.result_year),
   .rsp_day_difference (rsp_chan.day_difference)
);

`default_nettype wire

// File: tb/date_result_checker.sv
`timescale 1ns / 1ps

module date_result_checker import gdod_pkg::*; (
   input  logic clock,
   input  logic reset,
   gdod_req_if  req_mon,
   gdod_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   // expected results, oldest first
   rsp_item_type expected_dates [$];
   int mismatches = 0;
   int waiting    = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // calendar arithmetic on the proleptic gregorian calendar
   function automatic bit leap_year(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic longint month_length(input longint y, input int m);
      longint n;
      case (m)
         2:             n = leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   n = 30;
         default:       n = 31;
      endcase
      return n;
   endfunction

   function automatic longint floor_quot(input longint a, input longint b);
      return (a >= 0) ? a / b : -((-a + b - 1) / b);
   endfunction

   // day count from 0001-01-01, month clamped to 1..12, day taken linearly
   function automatic longint serial_day(input longint y, input logic [MONTH_W-1:0] m,
                                         input logic [DAY_W-1:0] d);
      longint p;
      longint n;
      int     mm;
      p  = y - 1;
      n  = p * 365 + floor_quot(p, 4) - floor_quot(p, 100) + floor_quot(p, 400);
      mm = (m == 0) ? 1 : ((m > MONTHS) ? MONTHS : int'(m));
      for (int k = 1; k < mm; k++) begin
         n += month_length(y, k);
      end
      return n + longint'(d) - 1;
   endfunction

   // back from a day count to year, month and day
   function automatic void calendar_from_serial(input longint n, output longint y,
                                                output int m, output longint d);
      longint q400;
      longint q100;
      longint q4;
      longint q1;
      q400 = n / 146097;
      n    = n % 146097;
      q100 = n / 36524;
      if (q100 > 3) begin
         q100 = 3;
      end
      n  -= q100 * 36524;
      q4  = n / 1461;
      n   = n % 1461;
      q1  = n / 365;
      if (q1 > 3) begin
         q1 = 3;
      end
      n -= q1 * 365;
      y  = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
      m  = 1;
      while (m < 12 && n >= month_length(y, m)) begin
         n -= month_length(y, m);
         m++;
      end
      d = n + 1;
   endfunction

   // shifted date, difference and flags for one request
   function automatic rsp_item_type shift_and_compare(input req_item_type rq);
      rsp_item_type res;
      longint bn;
      longint on;
      longint last;
      longint r;
      longint diff;
      longint ry;
      longint rd;
      int     rm;
      bn   = serial_day(rq.base_year, rq.base_month, rq.base_day);
      on   = serial_day(rq.other_year, rq.other_month, rq.other_day);
      last = serial_day(MAX_YEAR, MONTH_W'(MONTHS), DAY_W'(31));
      r    = bn + longint'($signed(rq.offset_days));
      res.result_out_of_range = 1'b0;
      if (r < 0) begin
         r = 0;
         res.result_out_of_range = 1'b1;
      end else if (r > last) begin
         r = last;
         res.result_out_of_range = 1'b1;
      end
      calendar_from_serial(r, ry, rm, rd);
      res.result_year  = YEAR_W'(ry);
      res.result_month = MONTH_W'(rm);
      res.result_day   = DAY_W'(rd);

      // difference saturates to the field
      diff = bn - on;
      if (diff > 4194303) begin
         diff = 4194303;
      end else if (diff < -4194304) begin
         diff = -4194304;
      end
      res.day_difference = DIFF_W'(diff);

      // flags on the raw fields
      res.base_valid = 1'b0;
      if (rq.base_month >= 1 && rq.base_month <= MONTHS && rq.base_day >= 1) begin
         res.base_valid = longint'(rq.base_day) <= month_length(rq.base_year, rq.base_month);
      end
      res.dates_equal = rq.base_year == rq.other_year && rq.base_month == rq.other_month &&
                        rq.base_day == rq.other_day;
      res.base_after_other = {rq.base_year, rq.base_month, rq.base_day} >
                             {rq.other_year, rq.other_month, rq.other_day};
      return res;
   endfunction

   task automatic report(input string line);
      mismatches++;
      $display("%0t: %s", $time, line);
   endtask

   task automatic check_field(input string name, input logic [DIFF_W-1:0] got,
                              input logic [DIFF_W-1:0] want);
      if (got !== want) begin
         report($sformatf("%s mismatch: got 'h%0h, expected 'h%0h", name, got, want));
      end
   endtask

   // predict on every request taken, compare on every result taken
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset) begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            expected_dates.push_back(shift_and_compare({req_mon.base_year,
               req_mon.base_month, req_mon.base_day, req_mon.offset_days,
               req_mon.other_year, req_mon.other_month, req_mon.other_day}));
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            seen = {rsp_mon.result_year, rsp_mon.result_month, rsp_mon.result_day,
                    rsp_mon.day_difference, rsp_mon.base_after_other,
                    rsp_mon.dates_equal, rsp_mon.base_valid, rsp_mon.result_out_of_range};
            if (expected_dates.size() == 0) begin
               report("result with no request outstanding");
            end else begin
               want = expected_dates.pop_front();
               check_field("result_year", DIFF_W'(seen.result_year), DIFF_W'(want.result_year));
               check_field("result_month", DIFF_W'(seen.result_month),
                           DIFF_W'(want.result_month));
               check_field("result_day", DIFF_W'(seen.result_day), DIFF_W'(want.result_day));
               check_field("day_difference", seen.day_difference, want.day_difference);
               check_field("base_after_other", DIFF_W'(seen.base_after_other),
                           DIFF_W'(want.base_after_other));
               check_field("dates_equal", DIFF_W'(seen.dates_equal), DIFF_W'(want.dates_equal));
               check_field("base_valid", DIFF_W'(seen.base_valid), DIFF_W'(want.base_valid));
               check_field("result_out_of_range", DIFF_W'(seen.result_out_of_range),
                           DIFF_W'(want.result_out_of_range));
            end
         end
         waiting = expected_dates.size();
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench import gdod_pkg::*;;

   localparam int REQ_W            = $bits(req_item_type);
   localparam int RANDOM_PER_PHASE = 140;
   localparam int QUIET_LIMIT      = 4000;
   localparam int DRAIN_CYCLES     = 250;
   localparam int OFF_MAX          = 4194303;
   localparam int OFF_MIN          = -4194304;
   localparam int SEND_IDLE [4]    = '{0, 78, 0, 35};
   localparam int RSP_STALL [4]    = '{0, 0, 78, 35};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic moved;
   int   fail_count;
   int   pending;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;

   gdod_req_if req_chan ();
   gdod_rsp_if rsp_chan ();

   gregorian_date_offset_and_difference_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_result_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result receiver stalls at random
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   assign moved = (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready);

   // watchdog on cycles with no request or result taken
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (moved === 1'b1) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   // present one request, entered and left at a falling edge
   task automatic send_request(input req_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.base_year   = item.base_year;
      req_chan.base_month  = item.base_month;
      req_chan.base_day    = item.base_day;
      req_chan.offset_days = item.offset_days;
      req_chan.other_year  = item.other_year;
      req_chan.other_month = item.other_month;
      req_chan.other_day   = item.other_day;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic send_dates(input int y, input int m, input int d, input int off,
                             input int oy, input int om, input int od);
      send_request({YEAR_W'(y), MONTH_W'(m), DAY_W'(d), OFF_W'(off),
                    YEAR_W'(oy), MONTH_W'(om), DAY_W'(od)});
   endtask

   // mostly real dates with offsets of every scale, some near the calendar ends, some noise
   function automatic req_item_type random_request();
      req_item_type item;
      int unsigned  kind;
      int           off;
      kind            = $urandom_range(99);
      item.base_year  = YEAR_W'($urandom_range(MAX_YEAR, 1));
      item.base_month = MONTH_W'($urandom_range(MONTHS, 1));
      item.base_day   = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(31, 29))
                                                 : DAY_W'($urandom_range(28, 1));
      case ($urandom_range(4))
         0:       off = int'($urandom_range(80)) - 40;
         1:       off = int'($urandom_range(800)) - 400;
         2:       off = int'($urandom_range(80000)) - 40000;
         3:       off = int'($urandom_range(3000000)) - 1500000;
         default: off = int'($urandom);
      endcase
      case ($urandom_range(3))
         0: begin
            item.other_year  = item.base_year;
            item.other_month = item.base_month;
            item.other_day   = item.base_day;
         end
         1: begin
            item.other_year  = item.base_year;
            item.other_month = item.base_month;
            item.other_day   = DAY_W'($urandom_range(31, 1));
         end
         2: begin
            item.other_year  = item.base_year;
            item.other_month = MONTH_W'($urandom_range(MONTHS, 1));
            item.other_day   = DAY_W'($urandom_range(28, 1));
         end
         default: begin
            item.other_year  = YEAR_W'($urandom_range(MAX_YEAR, 1));
            item.other_month = MONTH_W'($urandom_range(MONTHS, 1));
            item.other_day   = DAY_W'($urandom_range(28, 1));
         end
      endcase
      // push past the first or last year
      if (kind < 15) begin
         if ($urandom_range(1) == 0) begin
            item.base_year = YEAR_W'($urandom_range(3, 1));
            off            = -int'($urandom_range(2000));
         end else begin
            item.base_year = YEAR_W'(MAX_YEAR - int'($urandom_range(2)));
            off            = int'($urandom_range(2000));
         end
      end
      item.offset_days = OFF_W'(off);
      if (kind >= 85) begin
         item = REQ_W'({$urandom, $urandom, $urandom});
      end
      return item;
   endfunction

   // stimulus and verdict
   initial begin
      req_chan.valid       = 1'b0;
      req_chan.base_year   = '0;
      req_chan.base_month  = '0;
      req_chan.base_day    = '0;
      req_chan.offset_days = '0;
      req_chan.other_year  = '0;
      req_chan.other_month = '0;
      req_chan.other_day   = '0;
      rsp_chan.ready       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // leap rules and month and year wrap
      send_dates(2000, 2, 29, 1, 2000, 2, 29);
      send_dates(1900, 2, 28, 1, 1900, 3, 1);
      send_dates(1900, 2, 29, 0, 1899, 12, 31);
      send_dates(2024, 12, 31, 1, 2024, 1, 1);
      send_dates(2024, 3, 1, -1, 2025, 3, 1);
      send_dates(1601, 1, 1, 146097, 2001, 1, 1);
      // shifted date leaves the calendar at either end
      send_dates(1, 1, 1, -1, 1, 1, 2);
      send_dates(MAX_YEAR, 12, 31, 1, 1, 1, 1);
      send_dates(1, 1, 1, OFF_MAX, MAX_YEAR, 12, 31);
      send_dates(MAX_YEAR, 12, 31, OFF_MIN, 1, 1, 1);
      // all ones and all zeros, difference saturating both ways
      send_dates(16383, 15, 31, -1, 0, 0, 0);
      send_dates(0, 0, 0, 0, 16383, 15, 31);
      // year zero and years beyond the last
      send_dates(0, 2, 29, 366, 0, 3, 1);
      send_dates(12000, 6, 15, -2000, 12000, 6, 14);
      // months out of range are clamped, flags follow the raw fields
      send_dates(2023, 0, 15, 10, 2023, 1, 15);
      send_dates(2023, 13, 1, 5, 2023, 12, 31);
      // days spilling into neighbouring months, then a plain date and one shifted below year one
      send_dates(2023, 4, 31, 0, 2023, 5, 1);
      send_dates(2023, 3, 0, 0, 2023, 2, 28);
      send_dates(2023, 5, 10, 0, 2023, 5, 11);
      send_dates(2023, 5, 10, -3652058, 2023, 4, 10);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = SEND_IDLE[ph];
         rsp_stall_pct = RSP_STALL[ph];
         repeat (RANDOM_PER_PHASE) send_request(random_request());
      end

      // drain outstanding results
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
src/gdod_pkg.sv
src/gdod_req_if.sv
src/gdod_rsp_if.sv
src/gdod_ctrl.sv
src/gdod_dpath.sv
src/gregorian_date_offset_and_difference_core.sv
src/gdod_checker.sv
tb/date_result_checker.sv
tb/testbench.sv
